[hdl/assert_macros.svh]
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/pba_pkg.sv]
package pba_pkg;

    localparam int NUM_POOLS    = 3;
    localparam int MAX_PAGES_DEF = 8;
    localparam int SIZE_W       = 21;
    localparam int OFF_W        = 20;
    localparam int IDX_W        = 3;
    localparam int SHIFT_W      = 5;
    localparam int POOL_W       = 2;

    localparam logic [SIZE_W-1:0] PAGE_LIMIT    = 21'h10_0000;
    localparam logic [SIZE_W-1:0] PAGE_SIZE_RST = 21'd1024;

    typedef enum logic {
        CMD_ALLOC  = 1'b0,
        CMD_REWIND = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_GRANT     = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SLOT   = 2'd2,
        ST_REWOUND   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_OPEN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              fits;
        logic [OFF_W-1:0]  aligned;
        logic [SIZE_W-1:0] end_off;
    } t_fit;

endpackage

[hdl/pba_intf.sv]
interface pba_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [pba_pkg::POOL_W-1:0]    pool;
    logic [pba_pkg::SIZE_W-1:0]    alloc_size;
    logic [pba_pkg::SHIFT_W-1:0]   align_shift;

    modport source (output valid, cmd, pool, alloc_size, align_shift, input ready);
    modport sink   (input valid, cmd, pool, alloc_size, align_shift, output ready);
endinterface

interface pba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [pba_pkg::IDX_W-1:0]     page_index;
    logic [pba_pkg::OFF_W-1:0]     byte_offset;
    logic                          opened_page;

    modport source (output valid, status, page_index, byte_offset, opened_page, input ready);
    modport sink   (input valid, status, page_index, byte_offset, opened_page, output ready);
endinterface

interface pba_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pba_pkg::SIZE_W-1:0]    page_size;

    modport source (output valid, page_size, input ready);
    modport sink   (input valid, page_size, output ready);
endinterface

[hdl/paged_bump_allocator_core.sv]
// Paged bump allocator for three pools (upload, readback, device-only), each
// with up to MAX_PAGES pages. Page offsets live in one RAM with a registered
// read; a valid bit per entry makes unwritten or rewound entries read as zero,
// so there is no clearing pass after reset or on a rewind. One request is
// handled at a time. Rewind, bad pool and too-large requests go straight to
// the result state. An allocation walks the pool's open pages one per cycle
// through the RAM read port and is granted from the first page that fits;
// else it opens a new page, or finds no slot once MAX_PAGES pages are open.
// The next request is accepted in the cycle after the result is loaded into
// the output register. A new request is accepted while the previous result
// still waits in the output register. page_size may be written only while
// idle.
`include "assert_macros.svh"

module paged_bump_allocator_core #(
    parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pba_req_if.sink   i_req,
    pba_rsp_if.source o_rsp,
    pba_cfg_if.sink   i_cfg
);

    localparam int DEPTH = pba_pkg::NUM_POOLS * MAX_PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_PAGES + 1);
    localparam int SW    = pba_pkg::SIZE_W;

    pba_pkg::t_state r_state, n_state;

    logic [SW-1:0]                  r_page_size;
    logic [SW-1:0]                  psize;
    logic [pba_pkg::POOL_W-1:0]     r_pool, n_pool;
    logic [SW-1:0]                  r_size, n_size;
    logic [pba_pkg::SHIFT_W-1:0]    r_shift, n_shift;
    logic [AW-1:0]                  r_base, n_base;
    logic [CW-1:0]                  r_page, n_page;
    logic [CW-1:0]                  r_npages, n_npages;
    logic [CW-1:0]                  r_pages [pba_pkg::NUM_POOLS];
    logic [CW-1:0]                  req_npages;
    logic                           pages_we;
    logic [DEPTH-1:0]               r_vld, n_vld;
    logic                           r_rd_vld;

    pba_pkg::t_status               r_res_status, n_res_status;
    logic [CW-1:0]                  r_res_idx, n_res_idx;
    logic [pba_pkg::OFF_W-1:0]      r_res_off, n_res_off;
    logic                           r_res_open, n_res_open;

    logic                           r_out_valid;
    pba_pkg::t_status               r_out_status;
    logic [pba_pkg::IDX_W-1:0]      r_out_idx;
    logic [pba_pkg::OFF_W-1:0]      r_out_off;
    logic                           r_out_open;

    logic                           accept;
    logic                           out_load;
    logic                           ram_wr_en;
    logic [AW-1:0]                  ram_wr_addr;
    logic [SW-1:0]                  ram_wr_data;
    logic                           ram_rd_en;
    logic [AW-1:0]                  ram_rd_addr;
    logic [SW-1:0]                  ram_rd_data;
    logic [SW-1:0]                  cur_off;
    pba_pkg::t_fit                  fit;
    logic                           walk_more;
    logic                           req_bad_pool;
    logic                           req_too_big;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == pba_pkg::S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_load    = (r_state == pba_pkg::S_DONE) && (!r_out_valid || o_rsp.ready);

    assign psize        = (r_page_size > pba_pkg::PAGE_LIMIT) ? pba_pkg::PAGE_LIMIT : r_page_size;
    assign req_bad_pool = i_req.pool >= pba_pkg::POOL_W'(pba_pkg::NUM_POOLS);
    assign req_too_big  = i_req.alloc_size > psize;
    assign req_npages   = req_bad_pool ? '0 : r_pages[i_req.pool];

    assign cur_off   = r_rd_vld ? ram_rd_data : '0;
    assign walk_more = (32'(r_page) + 1) < 32'(r_npages);

    pba_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    pba_fit u_fit (
        .i_offset (cur_off),
        .i_shift  (r_shift),
        .i_size   (r_size),
        .i_psize  (psize),
        .o_fit    (fit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pba_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req.cmd == pba_pkg::CMD_REWIND || req_bad_pool || req_too_big) begin
                        n_state = pba_pkg::S_DONE;
                    end else if (req_npages == '0) begin
                        n_state = pba_pkg::S_OPEN;
                    end else begin
                        n_state = pba_pkg::S_WALK;
                    end
                end
            end
            pba_pkg::S_WALK: begin
                if (fit.fits) begin
                    n_state = pba_pkg::S_DONE;
                end else if (!walk_more) begin
                    n_state = pba_pkg::S_OPEN;
                end
            end
            pba_pkg::S_OPEN: n_state = pba_pkg::S_DONE;
            pba_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = pba_pkg::S_IDLE;
                end
            end
            default: n_state = pba_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_pool       = r_pool;
        n_size       = r_size;
        n_shift      = r_shift;
        n_base       = r_base;
        n_page       = r_page;
        n_npages     = r_npages;
        n_vld        = r_vld;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_off    = r_res_off;
        n_res_open   = r_res_open;
        pages_we     = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = AW'(32'(r_base) + 32'(r_page));
        ram_wr_data  = fit.end_off;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = AW'(32'(r_base) + 32'(r_page) + 1);
        case (r_state)
            pba_pkg::S_IDLE: begin
                n_pool       = i_req.pool;
                n_size       = i_req.alloc_size;
                n_shift      = i_req.align_shift;
                n_base       = AW'(32'(i_req.pool) * MAX_PAGES);
                n_page       = '0;
                n_npages     = req_npages;
                n_res_status = pba_pkg::ST_GRANT;
                n_res_idx    = '0;
                n_res_off    = '0;
                n_res_open   = 1'b0;
                ram_rd_addr  = AW'(32'(i_req.pool) * MAX_PAGES);
                if (accept) begin
                    if (i_req.cmd == pba_pkg::CMD_REWIND) begin
                        n_vld        = '0;
                        n_res_status = pba_pkg::ST_REWOUND;
                    end else if (req_bad_pool) begin
                        n_res_status = pba_pkg::ST_NO_SLOT;
                    end else if (req_too_big) begin
                        n_res_status = pba_pkg::ST_TOO_LARGE;
                    end else begin
                        ram_rd_en = 1'b1;
                    end
                end
            end
            pba_pkg::S_WALK: begin
                if (fit.fits) begin
                    ram_wr_en          = 1'b1;
                    n_vld[ram_wr_addr] = 1'b1;
                    n_res_idx          = r_page;
                    n_res_off          = fit.aligned;
                end else if (walk_more) begin
                    ram_rd_en = 1'b1;
                    n_page    = r_page + 1'b1;
                end else begin
                    n_page = r_npages;
                end
            end
            pba_pkg::S_OPEN: begin
                if (32'(r_page) >= MAX_PAGES) begin
                    n_res_status = pba_pkg::ST_NO_SLOT;
                end else begin
                    ram_wr_en          = 1'b1;
                    ram_wr_data        = r_size;
                    n_vld[ram_wr_addr] = 1'b1;
                    pages_we           = 1'b1;
                    n_res_idx          = r_page;
                    n_res_open         = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pba_pkg::S_IDLE;
            r_page_size <= pba_pkg::PAGE_SIZE_RST;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < pba_pkg::NUM_POOLS; i++) begin
                r_pages[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            if (i_cfg.valid && i_cfg.ready) begin
                r_page_size <= i_cfg.page_size;
            end
            if (pages_we) begin
                r_pages[r_pool] <= r_page + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pool       <= n_pool;
        r_size       <= n_size;
        r_shift      <= n_shift;
        r_base       <= n_base;
        r_page       <= n_page;
        r_npages     <= n_npages;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_off    <= n_res_off;
        r_res_open   <= n_res_open;
        if (ram_rd_en) begin
            r_rd_vld <= r_vld[ram_rd_addr];
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= pba_pkg::IDX_W'(r_res_idx);
            r_out_off    <= r_res_off;
            r_out_open   <= r_res_open;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.page_index  = r_out_idx;
    assign o_rsp.byte_offset = r_out_off;
    assign o_rsp.opened_page = r_out_open;

    `ASSERT_IMP(a_nogrant_zero, o_rsp.valid && o_rsp.status != pba_pkg::ST_GRANT, o_rsp.page_index == '0 && o_rsp.byte_offset == '0 && !o_rsp.opened_page)
    `ASSERT_IMP(a_open_at_zero, o_rsp.valid && o_rsp.opened_page, o_rsp.byte_offset == '0 && o_rsp.status == pba_pkg::ST_GRANT)
    `ASSERT_IMP(a_wr_state, ram_wr_en, r_state == pba_pkg::S_WALK || r_state == pba_pkg::S_OPEN)
    `ASSERT_NXT(a_accept_busy, i_req.valid && i_req.ready, r_state != pba_pkg::S_IDLE)

endmodule

[hdl/pba_ram.sv]
module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/pba_fit.sv]
module pba_fit (
    input  logic [pba_pkg::SIZE_W-1:0]  i_offset,
    input  logic [pba_pkg::SHIFT_W-1:0] i_shift,
    input  logic [pba_pkg::SIZE_W-1:0]  i_size,
    input  logic [pba_pkg::SIZE_W-1:0]  i_psize,
    output pba_pkg::t_fit               o_fit
);

    localparam int AL_W = pba_pkg::SIZE_W + 2;

    logic [AL_W-2:0] mask;
    logic [AL_W-1:0] bumped;
    logic [AL_W-1:0] aligned;
    logic [AL_W:0]   end_off;

    // shifts of 22 and up give an all-ones mask; any nonzero offset then aligns past the page
    assign mask    = ~({(AL_W-1){1'b1}} << i_shift);
    assign bumped  = AL_W'(i_offset) + AL_W'(mask);
    assign aligned = bumped & ~AL_W'(mask);
    assign end_off = (AL_W+1)'(aligned) + (AL_W+1)'(i_size);

    assign o_fit.fits    = end_off <= (AL_W+1)'(i_psize);
    assign o_fit.aligned = aligned[pba_pkg::OFF_W-1:0];
    assign o_fit.end_off = end_off[pba_pkg::SIZE_W-1:0];

endmodule

[tb/sv/paged_bump_allocator_core_tb.sv]
module paged_bump_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int MAX_PAGES       = MAX_PAGES_DEF;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int PRESSURE_PHASE  = 5;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = MAX_PAGES + 8;

    localparam logic [POOL_W-1:0] POOL_UPLOAD   = 2'd0;
    localparam logic [POOL_W-1:0] POOL_READBACK = 2'd1;
    localparam logic [POOL_W-1:0] POOL_DEVICE   = 2'd2;
    localparam logic [POOL_W-1:0] POOL_BAD      = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 21'h1F_FFFF;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  page_index;
        logic [OFF_W-1:0]  byte_offset;
        logic              opened_page;
    } t_rsp_exp;

    typedef struct packed {
        logic                is_cfg;
        t_cmd                cmd;
        logic [POOL_W-1:0]   pool;
        logic [SIZE_W-1:0]   size;
        logic [SHIFT_W-1:0]  shift;
        logic                typed;
        t_rsp_exp            want;
    } t_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } t_rx_mode;

    localparam logic ROW_REQ  = 1'b0;
    localparam logic ROW_CFG  = 1'b1;
    localparam logic BY_MODEL = 1'b0;
    localparam logic TYPED    = 1'b1;

    localparam t_rsp_exp NO_RSP        = '{ST_GRANT, 3'd0, 20'd0, 1'b0};
    localparam t_rsp_exp RSP_TOO_LARGE = '{ST_TOO_LARGE, 3'd0, 20'd0, 1'b0};
    localparam t_rsp_exp RSP_NO_SLOT   = '{ST_NO_SLOT, 3'd0, 20'd0, 1'b0};
    localparam t_rsp_exp RSP_REWOUND   = '{ST_REWOUND, 3'd0, 20'd0, 1'b0};

    localparam int N_DIRECTED = 30;

    // page_size starts at its reset value of 1024
    t_row directed_rows [N_DIRECTED] = '{
        '{ROW_REQ, CMD_ALLOC,  POOL_UPLOAD,   21'd100,     5'd0,  TYPED,
          '{ST_GRANT, 3'd0, 20'd0, 1'b1}},
        '{ROW_REQ, CMD_ALLOC,  POOL_UPLOAD,   21'd10,      5'd4,  TYPED,
          '{ST_GRANT, 3'd0, 20'd112, 1'b0}},
        '{ROW_REQ, CMD_ALLOC,  POOL_UPLOAD,   21'd1024,    5'd0,  TYPED,
          '{ST_GRANT, 3'd1, 20'd0, 1'b1}},
        '{ROW_REQ, CMD_ALLOC,  POOL_UPLOAD,   21'd1025,    5'd0,  TYPED, RSP_TOO_LARGE},
        '{ROW_REQ, CMD_ALLOC,  POOL_BAD,      21'd5,       5'd3,  TYPED, RSP_NO_SLOT},
        '{ROW_REQ, CMD_ALLOC,  POOL_READBACK, 21'd0,       5'd31, TYPED,
          '{ST_GRANT, 3'd0, 20'd0, 1'b1}},
        '{ROW_REQ, CMD_ALLOC,  POOL_READBACK, 21'd0,       5'd31, TYPED,
          '{ST_GRANT, 3'd0, 20'd0, 1'b0}},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   SIZE_MAX,    5'd31, TYPED, RSP_TOO_LARGE},
        // fill every slot of the device pool
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1024,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1024,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1024,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1024,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1024,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1024,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1024,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1024,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1,       5'd0,  TYPED, RSP_NO_SLOT},
        '{ROW_REQ, CMD_REWIND, POOL_BAD,      SIZE_MAX,    5'd31, TYPED, RSP_REWOUND},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd1024,    5'd0,  TYPED,
          '{ST_GRANT, 3'd0, 20'd0, 1'b0}},
        '{ROW_REQ, CMD_ALLOC,  POOL_UPLOAD,   21'd1,       5'd20, BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_UPLOAD,   21'd1,       5'd20, BY_MODEL, NO_RSP},
        // page size above range clamps to 1 MiB
        '{ROW_CFG, CMD_ALLOC,  POOL_UPLOAD,   SIZE_MAX,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_READBACK, SIZE_MAX,    5'd0,  TYPED, RSP_TOO_LARGE},
        '{ROW_REQ, CMD_ALLOC,  POOL_READBACK, PAGE_LIMIT,  5'd0,  BY_MODEL, NO_RSP},
        // zero-size grant at the very end of a full 1 MiB page
        '{ROW_REQ, CMD_ALLOC,  POOL_READBACK, 21'd0,       5'd0,  BY_MODEL, NO_RSP},
        '{ROW_CFG, CMD_ALLOC,  POOL_UPLOAD,   21'd0,       5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_UPLOAD,   21'd1,       5'd0,  TYPED, RSP_TOO_LARGE},
        '{ROW_REQ, CMD_ALLOC,  POOL_DEVICE,   21'd0,       5'd7,  BY_MODEL, NO_RSP},
        // lowered page size leaves a page over-full
        '{ROW_CFG, CMD_ALLOC,  POOL_UPLOAD,   21'd1024,    5'd0,  BY_MODEL, NO_RSP},
        '{ROW_REQ, CMD_ALLOC,  POOL_READBACK, 21'd16,      5'd0,  BY_MODEL, NO_RSP}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pba_req_if req_ch ();
    pba_rsp_if rsp_ch ();
    pba_cfg_if cfg_ch ();

    paged_bump_allocator_core #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    logic [SIZE_W-1:0] page_fill [NUM_POOLS][MAX_PAGES];
    int                pages_in_use [NUM_POOLS];
    logic [SIZE_W-1:0] cur_page_size;

    t_rsp_exp pending_grants [$];
    int       error_count = 0;
    int       burst_left  = 0;
    int       stall_count = 0;

    function automatic t_rsp_exp bump_allocate(t_cmd cmd, logic [POOL_W-1:0] pool,
                                               logic [SIZE_W-1:0] size,
                                               logic [SHIFT_W-1:0] shift);
        t_rsp_exp    res;
        logic [63:0] limit;
        logic [63:0] mask;
        logic [63:0] aligned;
        int          n;
        res = NO_RSP;
        if (cmd == CMD_REWIND) begin
            foreach (page_fill[i, j]) page_fill[i][j] = '0;
            res.status = ST_REWOUND;
            return res;
        end
        res.status = ST_NO_SLOT;
        if (pool >= NUM_POOLS) return res;
        limit = (cur_page_size > PAGE_LIMIT) ? 64'(PAGE_LIMIT) : 64'(cur_page_size);
        if (64'(size) > limit) begin
            res.status = ST_TOO_LARGE;
            return res;
        end
        mask = (64'd1 << shift) - 64'd1;
        n = pages_in_use[pool];
        for (int p = 0; p < n; p++) begin
            aligned = (64'(page_fill[pool][p]) + mask) & ~mask;
            if (aligned + 64'(size) <= limit) begin
                page_fill[pool][p] = SIZE_W'(aligned + 64'(size));
                res.status      = ST_GRANT;
                res.page_index  = IDX_W'(p);
                res.byte_offset = OFF_W'(aligned);
                return res;
            end
        end
        if (n >= MAX_PAGES) return res;
        page_fill[pool][n] = size;
        pages_in_use[pool] = n + 1;
        res.status      = ST_GRANT;
        res.page_index  = IDX_W'(n);
        res.opened_page = 1'b1;
        return res;
    endfunction

    // all tasks below are entered and left at a falling edge
    task automatic pause(input int n);
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            pause(($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1));
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        if (pending_grants.size() != 0) begin
            req_ch.valid <= 1'b0;
            while (pending_grants.size() != 0) @(negedge i_clk);
        end
    endtask

    task automatic issue_request(input t_cmd cmd, input logic [POOL_W-1:0] pool,
                                 input logic [SIZE_W-1:0] size,
                                 input logic [SHIFT_W-1:0] shift,
                                 input logic typed, input t_rsp_exp typed_rsp);
        t_rsp_exp predicted;
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.pool        <= pool;
        req_ch.alloc_size  <= size;
        req_ch.align_shift <= shift;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predicted = bump_allocate(cmd, pool, size, shift);
        pending_grants.push_back(typed ? typed_rsp : predicted);
        @(negedge i_clk);
    endtask

    task automatic set_page_size(input logic [SIZE_W-1:0] value);
        wait_drained();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.page_size <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cur_page_size = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : rsp_sink
        t_rx_mode mode;
        int       left;
        int       tick;
        rsp_ch.ready = 1'b0;
        mode = RX_OPEN;
        left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(3));
                left = $urandom_range(200, 20);
            end
            left--;
            tick++;
            case (mode)
                RX_OPEN:   rsp_ch.ready <= 1'b1;
                RX_COIN:   rsp_ch.ready <= 1'($urandom_range(1));
                RX_MOSTLY: rsp_ch.ready <= ($urandom_range(4) != 0);
                default:   rsp_ch.ready <= ((tick % 16) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_rsp
        t_rsp_exp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected result: status %0d", rsp_ch.status);
                error_count++;
            end else begin
                want = pending_grants.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.page_index !== want.page_index) begin
                    $error("page_index: expected %0d, got %0d",
                           want.page_index, rsp_ch.page_index);
                    error_count++;
                end
                if (rsp_ch.byte_offset !== want.byte_offset) begin
                    $error("byte_offset: expected %0d, got %0d",
                           want.byte_offset, rsp_ch.byte_offset);
                    error_count++;
                end
                if (rsp_ch.opened_page !== want.opened_page) begin
                    $error("opened_page: expected %0d, got %0d",
                           want.opened_page, rsp_ch.opened_page);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin : stimulus
        t_row              row;
        logic [SIZE_W-1:0] ps;
        logic [SIZE_W-1:0] eff;
        logic [SIZE_W-1:0] sz;
        logic [SHIFT_W-1:0] sh;
        logic [POOL_W-1:0] pl;
        t_cmd              cmd;
        int                pick;

        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_ALLOC;
        req_ch.pool        = POOL_UPLOAD;
        req_ch.alloc_size  = '0;
        req_ch.align_shift = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.page_size   = PAGE_SIZE_RST;

        cur_page_size = PAGE_SIZE_RST;
        foreach (page_fill[i, j]) page_fill[i][j] = '0;
        foreach (pages_in_use[i]) pages_in_use[i] = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                set_page_size(row.size);
            end else begin
                pace();
                issue_request(row.cmd, row.pool, row.size, row.shift, row.typed, row.want);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       ps = 21'd1;
                1:       ps = SIZE_MAX;
                2:       ps = 21'd0;
                3:       ps = PAGE_LIMIT;
                default: ps = ($urandom_range(3) == 0) ? SIZE_W'($urandom_range(SIZE_MAX))
                                                      : SIZE_W'($urandom_range(4096, 16));
            endcase
            set_page_size(ps);
            eff = (ps > PAGE_LIMIT) ? PAGE_LIMIT : ps;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pace();
                if ((phase == PRESSURE_PHASE && k == ITEMS_PER_PHASE / 2)
                    || $urandom_range(99) == 0) begin
                    wait_drained();
                end
                pick = $urandom_range(99);
                cmd  = CMD_ALLOC;
                pl   = POOL_W'($urandom_range(NUM_POOLS - 1));
                sz   = SIZE_W'($urandom_range(SIZE_MAX));
                sh   = SHIFT_W'($urandom_range(31));
                if (pick < 4) begin
                    cmd = CMD_REWIND;
                    pl  = POOL_W'($urandom_range(3));
                end else if (pick < 7) begin
                    pl = POOL_BAD;
                end else if (pick >= 12) begin
                    sz = SIZE_W'($urandom_range(32'(eff) >> $urandom_range(4)));
                    sh = SHIFT_W'(($urandom_range(7) == 0) ? $urandom_range(12)
                                                          : $urandom_range(6));
                end
                issue_request(cmd, pl, sz, sh, BY_MODEL, NO_RSP);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
